FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/isrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isrp_pkg;

   localparam int KEY_W     = 10;
   localparam int RW_W      = 16;
   localparam int CNT_W     = 11;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int KEY_LIMIT = 1 << KEY_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_FIND   = 2'd2,
      MODE_PICK   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NOCHANGE = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_PICK
   } ctl_state_type;

   typedef struct packed {
      logic clear;
      logic take;
      logic exec;
      logic pick_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic pick_go;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: design/isrp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface isrp_req_if;
   import isrp_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [KEY_W-1:0]    key;
   logic [RW_W-1:0]     random_word;

   modport source (output valid, output mode, output key, output random_word, input ready);
   modport sink (input valid, input mode, input key, input random_word, output ready);
endinterface

`default_nettype wire

FILE: design/isrp_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface isrp_rsp_if;
   import isrp_pkg::*;

   logic                valid;
   logic                ready;
   logic                found;
   logic [KEY_W-1:0]    picked_key;
   logic [CNT_W-1:0]    member_count;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output found, output picked_key, output member_count,
                   output status, input ready);
   modport sink (input valid, input found, input picked_key, input member_count,
                 input status, output ready);
endinterface

`default_nettype wire

FILE: design/isrp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module isrp_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/isrp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module isrp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire isrp_pkg::dp_status_type stat,
   output logic                        req_ready,
   output isrp_pkg::ctl_cmd_type       cmd
);
   import isrp_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (stat.pick_go) begin
               state_in = ST_PICK;
            end else if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_PICK: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_LOOK:  cmd.exec = stat.pick_go | stat.out_free;
         ST_PICK:  cmd.pick_out = stat.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: design/isrp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module isrp_dp #(
   parameter int KEY_SPACE = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire isrp_pkg::ctl_cmd_type         cmd,
   input  wire logic [isrp_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [isrp_pkg::KEY_W-1:0]    req_key,
   input  wire logic [isrp_pkg::RW_W-1:0]     req_random_word,
   output isrp_pkg::dp_status_type            stat,
   isrp_rsp_if.source                         rsp_if
);
   import isrp_pkg::*;

   localparam int DEPTH = (KEY_SPACE < KEY_LIMIT) ? KEY_SPACE : KEY_LIMIT;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = RW_W + CNT_W;

   mode_type            mode_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [PW-1:0]       prod_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [AW-1:0]       clr_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff;
   logic [KEY_W-1:0]    rsp_picked_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   status_type          rsp_status_ff, status_in;

   logic                pres_q;
   logic [AW-1:0]       slot_q;
   logic [KEY_W-1:0]    elem_q;

   logic                pres_we, pres_wd;
   logic [AW-1:0]       pres_wa, pres_ra;
   logic                elem_we, slot_we;
   logic [AW-1:0]       elem_wa, elem_ra, slot_wa, slot_wd;
   logic [KEY_W-1:0]    elem_wd;

   logic [CNT_W-1:0]    count_dec;
   logic [AW-1:0]       idx;
   logic                key_ok, is_member, room, do_add, do_rem;
   logic                load_exec, load_any;

   // reads
   assign count_dec = count_ff - CNT_W'(1);
   assign idx       = prod_ff[RW_W +: AW];
   assign pres_ra   = cmd.take ? req_key[AW-1:0] : key_ff[AW-1:0];
   assign elem_ra   = (!cmd.take && mode_ff == MODE_PICK) ? idx : count_dec[AW-1:0];

   // decision
   assign key_ok    = (32'(key_ff) < KEY_SPACE);
   assign is_member = pres_q & key_ok;
   assign room      = (count_ff < CNT_W'(DEPTH));
   assign do_add    = (mode_ff == MODE_ADD) && !is_member && key_ok && room;
   assign do_rem    = (mode_ff == MODE_REMOVE) && is_member;

   assign stat.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign stat.pick_go    = (mode_ff == MODE_PICK) && (count_ff != '0);
   assign stat.out_free   = !rsp_valid_ff || rsp_if.ready;

   // writes
   assign pres_we = cmd.clear | (cmd.exec & (do_add | do_rem));
   assign pres_wa = cmd.clear ? clr_ff : key_ff[AW-1:0];
   assign pres_wd = cmd.exec & do_add;
   assign elem_we = cmd.exec & (do_add | do_rem);
   assign elem_wa = do_add ? count_ff[AW-1:0] : slot_q;
   assign elem_wd = do_add ? key_ff : elem_q;
   assign slot_we = cmd.exec & (do_add | do_rem);
   assign slot_wa = do_add ? key_ff[AW-1:0] : elem_q[AW-1:0];
   assign slot_wd = do_add ? count_ff[AW-1:0] : slot_q;

   isrp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_pres (
      .clock   (clock),
      .wr_en   (pres_we),
      .wr_addr (pres_wa),
      .wr_data (pres_wd),
      .rd_addr (pres_ra),
      .rd_data (pres_q)
   );

   isrp_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_slot (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_addr (pres_ra),
      .rd_data (slot_q)
   );

   isrp_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_elem (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_wa),
      .wr_data (elem_wd),
      .rd_addr (elem_ra),
      .rd_data (elem_q)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.exec && do_add) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.exec && do_rem) begin
         count_in = count_dec;
      end
   end

   always_comb begin
      case (mode_ff)
         MODE_ADD:    status_in = do_add ? STATUS_DONE : STATUS_NOCHANGE;
         MODE_REMOVE: status_in = do_rem ? STATUS_DONE : STATUS_NOCHANGE;
         MODE_FIND:   status_in = STATUS_DONE;
         MODE_PICK:   status_in = (count_ff == '0) ? STATUS_EMPTY : STATUS_DONE;
         default:     status_in = STATUS_DONE;
      endcase
   end

   assign load_exec    = cmd.exec & !stat.pick_go;
   assign load_any     = load_exec | cmd.pick_out;
   assign rsp_valid_in = load_any | (rsp_valid_ff & !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear) clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         mode_ff <= mode_type'(req_mode);
         key_ff  <= req_key;
         prod_ff <= PW'(req_random_word) * PW'(count_ff);
      end
      if (load_exec) begin
         rsp_found_ff  <= (mode_ff != MODE_PICK) & is_member;
         rsp_picked_ff <= '0;
         rsp_count_ff  <= count_in;
         rsp_status_ff <= status_in;
      end else if (cmd.pick_out) begin
         rsp_found_ff  <= 1'b0;
         rsp_picked_ff <= elem_q;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= STATUS_DONE;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.found        = rsp_found_ff;
   assign rsp_if.picked_key   = rsp_picked_ff;
   assign rsp_if.member_count = rsp_count_ff;
   assign rsp_if.status       = rsp_status_ff;

endmodule

`default_nettype wire

FILE: design/indexed_set_random_pick.sv
// flow: ST_IDLE takes a request and issues the registered ram reads; ST_LOOK decides, writes the
//    single-write-port rams and loads the response register, but a non-empty pick reads and loads the
//    picked element in ST_PICK; loading stalls on rsp_if.ready, and requests are taken only in ST_IDLE
// reset: synchronous; count and response valid clear, then a membership clearing pass over
//    min(KEY_SPACE, 1024) entries runs with req_if.ready low
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module indexed_set_random_pick #(
   parameter int KEY_SPACE = 1024
) (
   input wire logic   clock,
   input wire logic   reset,
   isrp_req_if.sink   req_if,
   isrp_rsp_if.source rsp_if
);
   import isrp_pkg::*;

   localparam int DEPTH = (KEY_SPACE < KEY_LIMIT) ? KEY_SPACE : KEY_LIMIT;

   ctl_cmd_type   cmd;
   dp_status_type stat;
   logic          ready;

   isrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .stat      (stat),
      .req_ready (ready),
      .cmd       (cmd)
   );

   assign req_if.ready = ready;

   isrp_dp #(.KEY_SPACE(KEY_SPACE)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_if.mode),
      .req_key         (req_if.key),
      .req_random_word (req_if.random_word),
      .stat            (stat),
      .rsp_if          (rsp_if)
   );

   `ASSERT_IMPLIES(a_no_take_in_clear, clock, reset, cmd.clear, !req_if.ready)
   `ASSERT_IMPLIES(a_empty_pick, clock, reset, rsp_if.valid && rsp_if.status == STATUS_EMPTY, rsp_if.member_count == '0 && rsp_if.picked_key == '0)
   `ASSERT_IMPLIES(a_count_bound, clock, reset, rsp_if.valid, rsp_if.member_count <= CNT_W'(DEPTH))
   `ASSERT_NEXT(a_take_then_look, clock, reset, cmd.take, !req_if.ready)

endmodule

`default_nettype wire
